// ----- hw/rtl/lps_pkg.sv -----
// Shared constants, types and the per-channel sharpening function for the
// Laplacian sharpening core. No dependencies.
`default_nettype none

package lps_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int CFG_W = 12;
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int WM1_RESET = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
  localparam int HM1_RESET = ((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int LINE_W  = 2 * PIX_W;

  localparam int OBUF_DEPTH = 4;
  localparam int PTR_W      = $clog2(OBUF_DEPTH);
  localparam int OCC_W      = PTR_W + 1;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] px;
    logic             due;
    logic             top_row;
    logic             bottom_row;
    logic             first_col;
    logic             last_col;
    logic             last_pixel;
  } lps_stage_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            eol;
    logic            eof;
  } lps_result_t;

  function automatic logic [CH_W-1:0] sharpen(input logic [CH_W-1:0] c,
                                             input logic [CH_W-1:0] n,
                                             input logic [CH_W-1:0] s,
                                             input logic [CH_W-1:0] w,
                                             input logic [CH_W-1:0] e);
    logic [CH_W+2:0]        c5;
    logic [CH_W+1:0]        sum;
    logic signed [CH_W+3:0] v;
    logic [CH_W+3:0]        mag;
    c5  = (CH_W+3)'({c, 2'b00}) + (CH_W+3)'(c);
    sum = (CH_W+2)'(n) + (CH_W+2)'(s) + (CH_W+2)'(w) + (CH_W+2)'(e);
    v   = signed'({1'b0, c5}) - signed'({2'b00, sum});
    mag = v[CH_W+3] ? unsigned'(-v) : unsigned'(v);
    return (mag > (CH_W+4)'(255)) ? {CH_W{1'b1}} : mag[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lps_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lps_ctrl.sv -----
// Input stage: size registers, input and output position counters, line
// store read request and the stage register. Depends on lps_pkg.
`default_nettype none

module lps_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         drain,
  input  wire logic [lps_pkg::CH_W-1:0]     in_blue,
  input  wire logic [lps_pkg::CH_W-1:0]     in_green,
  input  wire logic [lps_pkg::CH_W-1:0]     in_red,
  input  wire logic                         wr_en,
  input  wire logic [lps_pkg::IDX_W-1:0]    wr_index,
  input  wire logic [lps_pkg::CFG_W-1:0]    wr_data,
  output logic                              re,
  output logic      [lps_pkg::COL_W-1:0]    raddr,
  output lps_pkg::lps_stage_t               st
);

  import lps_pkg::*;

  logic [COL_W-1:0] wm1, col, co, col_next, co_next;
  logic [ROW_W-1:0] hm1, row, ro, row_next, ro_next;
  logic             oc_nz, ignore, go, due;
  logic             col_last, row_last, co_last, ro_last, frame_last;

  always_comb begin
    oc_nz      = (co != '0) || (ro != '0);
    ignore     = drain && !oc_nz;
    go         = accept && !ignore;
    due        = oc_nz || (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0)) ||
                 ((row == '0) && ({1'b0, col} >= ({1'b0, wm1} + (COL_W+1)'(2))));
    col_last   = col >= wm1;
    row_last   = row >= hm1;
    co_last    = co >= wm1;
    ro_last    = ro >= hm1;
    frame_last = co_last && ro_last;

    if (col_last) begin
      col_next = '0;
      row_next = row_last ? '0 : row + ROW_W'(1);
    end else begin
      col_next = col + COL_W'(1);
      row_next = row;
    end
    co_next = co;
    ro_next = ro;
    if (due) begin
      if (frame_last) begin
        co_next = '0;
        ro_next = '0;
        if (drain) begin
          col_next = '0;
          row_next = '0;
        end
      end else if (co_last) begin
        co_next = '0;
        ro_next = ro + ROW_W'(1);
      end else begin
        co_next = co + COL_W'(1);
      end
    end
  end

  assign re    = go;
  assign raddr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1      <= COL_W'(WM1_RESET);
      hm1      <= ROW_W'(HM1_RESET);
      col      <= '0;
      row      <= '0;
      co       <= '0;
      ro       <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_IMAGE_WIDTH: begin
            if (32'(wr_data) < 32'd2) begin
              wm1 <= COL_W'(1);
            end else if (32'(wr_data) > 32'(MAX_WIDTH)) begin
              wm1 <= COL_W'(MAX_WIDTH - 1);
            end else begin
              wm1 <= COL_W'(wr_data - CFG_W'(1));
            end
          end
          REG_IMAGE_HEIGHT: begin
            if (32'(wr_data) < 32'd2) begin
              hm1 <= ROW_W'(1);
            end else if (32'(wr_data) > 32'(MAX_HEIGHT)) begin
              hm1 <= ROW_W'(MAX_HEIGHT - 1);
            end else begin
              hm1 <= ROW_W'(wr_data - CFG_W'(1));
            end
          end
          default: begin
          end
        endcase
      end
      if (go) begin
        col <= col_next;
        row <= row_next;
        co  <= co_next;
        ro  <= ro_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= go;
    end
    if (go) begin
      st.addr       <= col;
      st.px         <= drain ? '0 : {in_red, in_green, in_blue};
      st.due        <= due;
      st.top_row    <= ro == '0;
      st.bottom_row <= ro_last;
      st.first_col  <= co == '0;
      st.last_col   <= co_last;
      st.last_pixel <= frame_last;
    end
  end

  a_ignore_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && ignore) |=> ($stable(col) && $stable(row) && !st.valid))
    else $error("ignored drain advanced the input position");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    go |=> ((co <= wm1) && (ro <= hm1)))
    else $error("output position left the frame");

endmodule

`default_nettype wire

// ----- hw/rtl/lps_window.sv -----
// Window stage: line store write-back with forwarding, 3x3 window registers,
// mirrored neighbour selection and per-channel sharpening. Depends on lps_pkg.
`default_nettype none

module lps_window (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lps_pkg::lps_stage_t          st,
  input  wire logic                         re,
  input  wire logic [lps_pkg::COL_W-1:0]    raddr,
  input  wire logic [lps_pkg::LINE_W-1:0]   rdata,
  output logic                              we,
  output logic      [lps_pkg::COL_W-1:0]    waddr,
  output logic      [lps_pkg::LINE_W-1:0]   wdata,
  output logic                              res_valid,
  output lps_pkg::lps_result_t              res
);

  import lps_pkg::*;

  logic [PIX_W-1:0]  w_top, w_mid, w_bot, w_west;
  logic [LINE_W-1:0] fwd_data, line;
  logic              fwd;
  logic [PIX_W-1:0]  top, mid, nth, sou, wes, eas;
  logic [PIX_W-1:0]  sharp;

  always_comb begin
    line = fwd ? fwd_data : rdata;
    top  = line[LINE_W-1:PIX_W];
    mid  = line[PIX_W-1:0];
    nth  = st.top_row ? w_bot : w_top;
    sou  = st.bottom_row ? w_top : w_bot;
    eas  = st.last_col ? w_west : mid;
    wes  = st.first_col ? eas : w_west;
    for (int k = 0; k < 3; k++) begin
      sharp[k*CH_W +: CH_W] = sharpen(w_mid[k*CH_W +: CH_W], nth[k*CH_W +: CH_W],
                                      sou[k*CH_W +: CH_W], wes[k*CH_W +: CH_W],
                                      eas[k*CH_W +: CH_W]);
    end
  end

  assign we        = st.valid;
  assign waddr     = st.addr;
  assign wdata     = {mid, st.px};
  assign res_valid = st.valid && st.due;
  assign res.blue  = sharp[CH_W-1:0];
  assign res.green = sharp[2*CH_W-1:CH_W];
  assign res.red   = sharp[3*CH_W-1:2*CH_W];
  assign res.eol   = st.last_col;
  assign res.eof   = st.last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_top  <= '0;
      w_mid  <= '0;
      w_bot  <= '0;
      w_west <= '0;
      fwd    <= 1'b0;
    end else begin
      if (st.valid) begin
        w_west <= w_mid;
        w_top  <= top;
        w_mid  <= mid;
        w_bot  <= st.px;
      end
      fwd <= re && st.valid && (raddr == st.addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
  end

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(st.valid))
    else $error("forwarded line entry without a write-back");

endmodule

`default_nettype wire

// ----- hw/rtl/lps_outbuf.sv -----
// Result queue between the window stage and the output channel; also
// decides whether the input side may take a transfer. Depends on lps_pkg.
`default_nettype none

module lps_outbuf (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lps_pkg::lps_result_t  push_data,
  input  wire logic                  stage_busy,
  output logic                       space,
  output logic                       valid,
  input  wire logic                  ready,
  output lps_pkg::lps_result_t       head
);

  import lps_pkg::*;

  lps_result_t      q [OBUF_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [OCC_W-1:0] occ;
  logic             pop;

  assign valid = occ != '0;
  assign pop   = valid && ready;
  assign head  = q[rptr];
  assign space = ((OCC_W+1)'(occ) + (OCC_W+1)'(stage_busy)) < (OCC_W+1)'(OBUF_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      occ  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        occ <= occ + OCC_W'(1);
      end else if (pop && !push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (occ == OCC_W'(OBUF_DEPTH))))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && !valid) |=> valid)
    else $error("result into empty queue not presented");

endmodule

`default_nettype wire

// ----- hw/rtl/laplacian_sharpen_3x3_core.sv -----
// Top level of the 3x3 Laplacian sharpening core: line store RAM, input
// stage, window stage and result queue. Depends on lps_pkg and the lps_* modules.
//
// Takes one BGR pixel per clock in raster order while in_ready is high, and
// returns, per channel, |5*C - N - S - W - E| saturated to 255, with mirrored
// borders. A result leaves for the pixel one line and one pixel behind the input;
// send width+1 drain transfers after a frame to flush its tail, or start the
// next frame. Sustained rate is one transfer per cycle while the output takes
// results; a result passes the stage register and the result queue before the
// output. Two stored lines share one 48-bit RAM of MAX_WIDTH entries read and
// written once per cycle, and a four-entry result queue lets input continue
// while the output stalls. The line store needs no clearing after reset. Write
// image_width and image_height only between frames, with all results delivered.
`default_nettype none

module laplacian_sharpen_3x3_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       drain,
  input  wire logic [lps_pkg::CH_W-1:0]   in_blue,
  input  wire logic [lps_pkg::CH_W-1:0]   in_green,
  input  wire logic [lps_pkg::CH_W-1:0]   in_red,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [lps_pkg::CH_W-1:0]   out_blue,
  output logic      [lps_pkg::CH_W-1:0]   out_green,
  output logic      [lps_pkg::CH_W-1:0]   out_red,
  output logic                            end_of_line,
  output logic                            end_of_frame,
  input  wire logic                       wr_en,
  input  wire logic [lps_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [lps_pkg::CFG_W-1:0]  wr_data
);

  import lps_pkg::*;

  logic              accept, re, we, res_valid;
  logic [COL_W-1:0]  raddr, waddr;
  logic [LINE_W-1:0] rdata, wdata;
  lps_stage_t        st;
  lps_result_t       res, head;

  assign accept = in_valid && in_ready;

  lps_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .drain    (drain),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .re       (re),
    .raddr    (raddr),
    .st       (st)
  );

  lps_window u_window (
    .clk       (clk),
    .rst       (rst),
    .st        (st),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lps_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .stage_busy (st.valid),
    .space      (in_ready),
    .valid      (out_valid),
    .ready      (out_ready),
    .head       (head)
  );

  assign out_blue     = head.blue;
  assign out_green    = head.green;
  assign out_red      = head.red;
  assign end_of_line  = head.eol;
  assign end_of_frame = head.eof;

endmodule

`default_nettype wire
